// ===== design/pan_tilt_aim_solver_assert.svh =====
// ----------------------------------------------------------------------------
// pan_tilt_aim_solver assertion macros
// Property wrappers shared by the aim solver RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef PAN_TILT_AIM_SOLVER_ASSERT_SVH
`define PAN_TILT_AIM_SOLVER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PTAS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PTAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PTAS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define PTAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/ptas_pkg.sv =====
// ----------------------------------------------------------------------------
// ptas_pkg
// Widths, constants, register indexes and the arctangent table of the solver.
// ----------------------------------------------------------------------------
package ptas_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;

    // datapath widths
    localparam int POS_W      = 16;   // Q0.16 position
    localparam int RANGE_W    = 10;   // range in degrees
    localparam int ORIENT_W   = 16;   // Q1.14 matrix entry
    localparam int NORM_BIT   = 39;   // normalized magnitude MSB
    localparam int NW         = 42;   // normalized vector component
    localparam int XW         = 46;   // CORDIC x / y
    localparam int ZW         = 27;   // angle, 2^-16 degree units
    localparam int NUM_W      = 26;   // divider numerator / quotient
    localparam int V_W        = 28;   // unclamped position
    localparam int GAIN_W     = 22;   // CORDIC gain, signed Q1.20
    localparam int SPLIT      = 21;   // partial product split point
    localparam int GAIN_FRAC  = 20;
    localparam int SUM_W      = 64;
    localparam int ATAN_W     = 22;

    localparam logic signed [ZW-1:0]     ANG_180  = 27'sd11796480;
    localparam logic signed [GAIN_W-1:0] GAIN_Q20 = 22'sd1726753;
    localparam logic signed [V_W-1:0]    POS_ONE  = 28'sd65536;
    localparam logic [POS_W-1:0]         POS_MAX  = 16'hFFFF;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] ORIENT_ROW_0_RST = 48'h0000_0000_4000;
    localparam logic [CFG_DATA_W-1:0] ORIENT_ROW_1_RST = 48'h0000_4000_0000;
    localparam logic [CFG_DATA_W-1:0] ORIENT_ROW_2_RST = 48'h4000_0000_0000;
    localparam logic [RANGE_W-1:0]    PAN_RANGE_RST    = 10'd540;
    localparam logic [RANGE_W-1:0]    TILT_RANGE_RST   = 10'd270;
    localparam logic [31:0]           CENTER_RST       = 32'h8000_8000;

    // invert flag bits
    localparam int INV_PAN  = 0;
    localparam int INV_TILT = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ORIENT_ROW_0,
        REG_ORIENT_ROW_1,
        REG_ORIENT_ROW_2,
        REG_FIXTURE_POSITION,
        REG_PAN_RANGE_DEG,
        REG_TILT_RANGE_DEG,
        REG_CENTER_POSITIONS,
        REG_INVERT_FLAGS
    } cfg_reg_t;

    // atan(2^-i) in 2^-16 degree units
    function automatic logic [ATAN_W-1:0] atan_units(input int unsigned idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            0:       v = 22'd2949120;
            1:       v = 22'd1740967;
            2:       v = 22'd919879;
            3:       v = 22'd466945;
            4:       v = 22'd234379;
            5:       v = 22'd117304;
            6:       v = 22'd58666;
            7:       v = 22'd29335;
            8:       v = 22'd14668;
            9:       v = 22'd7334;
            10:      v = 22'd3667;
            11:      v = 22'd1833;
            12:      v = 22'd917;
            13:      v = 22'd458;
            14:      v = 22'd229;
            15:      v = 22'd115;
            16:      v = 22'd57;
            17:      v = 22'd29;
            18:      v = 22'd14;
            19:      v = 22'd7;
            20:      v = 22'd4;
            21:      v = 22'd2;
            22:      v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/ptas_if.sv =====
// ----------------------------------------------------------------------------
// ptas_if
// Valid/ready channels of the aim solver: aim requests, results, config.
// ----------------------------------------------------------------------------
interface ptas_in_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic signed [COORD_WIDTH-1:0] vec_x;
    logic signed [COORD_WIDTH-1:0] vec_y;
    logic signed [COORD_WIDTH-1:0] vec_z;

    modport source (output valid, opcode, vec_x, vec_y, vec_z, input ready);
    modport sink   (input valid, opcode, vec_x, vec_y, vec_z, output ready);
endinterface

interface ptas_out_if;
    import ptas_pkg::*;
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] pan_position;
    logic [POS_W-1:0] tilt_position;
    logic             reachable;

    modport source (output valid, pan_position, tilt_position, reachable, input ready);
    modport sink   (input valid, pan_position, tilt_position, reachable, output ready);
endinterface

interface ptas_cfg_if;
    import ptas_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/ptas_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// ptas_cordic_stage
// One registered vectoring CORDIC micro-rotation, shift fixed by STAGE.
// ----------------------------------------------------------------------------
module ptas_cordic_stage #(
    parameter int STAGE = 0
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [ptas_pkg::XW-1:0] x_in,
    input  logic signed [ptas_pkg::XW-1:0] y_in,
    input  logic signed [ptas_pkg::ZW-1:0] z_in,
    output logic signed [ptas_pkg::XW-1:0] x_out,
    output logic signed [ptas_pkg::XW-1:0] y_out,
    output logic signed [ptas_pkg::ZW-1:0] z_out
);
    import ptas_pkg::*;

    logic signed [XW-1:0] x_sh;
    logic signed [XW-1:0] y_sh;
    logic signed [ZW-1:0] ang;
    logic signed [XW-1:0] x_next, y_next, x_reg, y_reg;
    logic signed [ZW-1:0] z_next, z_reg;

    // rotate toward y = 0; no rotation when y is already zero
    always_comb
    begin
        x_sh   = x_in >>> STAGE;
        y_sh   = y_in >>> STAGE;
        ang    = signed'(ZW'(atan_units(STAGE)));
        x_next = x_in;
        y_next = y_in;
        z_next = z_in;
        if (y_in > 0)
        begin
            x_next = x_in + y_sh;
            y_next = y_in - x_sh;
            z_next = z_in + ang;
        end
        else if (y_in < 0)
        begin
            x_next = x_in - y_sh;
            y_next = y_in + x_sh;
            z_next = z_in - ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// ===== design/ptas_div_stage.sv =====
// ----------------------------------------------------------------------------
// ptas_div_stage
// One registered restoring-division step, resolving quotient bit BIT.
// ----------------------------------------------------------------------------
module ptas_div_stage #(
    parameter int BIT = 0
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic [ptas_pkg::RANGE_W-1:0]     divisor,
    input  logic [ptas_pkg::NUM_W-1:0]       num_in,
    input  logic [ptas_pkg::RANGE_W-1:0]     rem_in,
    input  logic [ptas_pkg::NUM_W-1:0]       quo_in,
    output logic [ptas_pkg::NUM_W-1:0]       num_out,
    output logic [ptas_pkg::RANGE_W-1:0]     rem_out,
    output logic [ptas_pkg::NUM_W-1:0]       quo_out
);
    import ptas_pkg::*;

    logic [RANGE_W:0]   trial;
    logic [RANGE_W-1:0] rem_next, rem_reg;
    logic [NUM_W-1:0]   quo_next, quo_reg, num_reg;

    // shift in the next numerator bit, subtract when it fits
    always_comb
    begin
        trial    = {rem_in, num_in[BIT]};
        quo_next = quo_in;
        rem_next = trial[RANGE_W-1:0];
        if (trial >= {1'b0, divisor})
        begin
            rem_next      = RANGE_W'(trial - {1'b0, divisor});
            quo_next[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_in;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign num_out = num_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;

endmodule

// ===== design/pan_tilt_aim_solver.sv =====
// ----------------------------------------------------------------------------
// pan_tilt_aim_solver
// Turns a world direction or target point into pan/tilt fixture positions.
// ----------------------------------------------------------------------------
// Usage:
//   aim    : request channel (opcode, vec_x/y/z). A transaction is taken when
//            valid and ready are high at a rising clock edge.
//   result : one transaction per request, in order: pan_position,
//            tilt_position (Q0.16) and reachable.
//   cfg    : register writes (index, data); always ready. Write only while
//            no request is in flight.
// Throughput: one request per cycle, sustained while the result channel is not stalled.
// Pipeline: from acceptance to result valid a request passes the two chained
//   CORDIC pipelines (one stage per iteration) and the 26-stage restoring
//   dividers that scale the angles by the travel ranges.
// Reset: all stage valids clear and the registers take their defaults
//   (identity orientation, origin fixture, 540/270 degree ranges, centers
//   at mid travel, no inversion).
// Stall: the whole pipeline holds while the result register is full and the
//   receiver is not ready; aim.ready drops in the same cycle.
// ----------------------------------------------------------------------------
`include "pan_tilt_aim_solver_assert.svh"

module pan_tilt_aim_solver #(
    parameter int COORD_WIDTH       = 16,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    ptas_in_if.sink    aim,
    ptas_out_if.source result,
    ptas_cfg_if.sink   cfg
);
    import ptas_pkg::*;

    localparam int CW      = COORD_WIDTH;
    localparam int N       = CORDIC_ITERATIONS;
    localparam int DW      = CW + 1;             // world vector after subtract
    localparam int PW      = CW + 17;            // matrix product
    localparam int LW      = CW + 19;            // fixture vector
    localparam int MSB_W   = $clog2(LW);
    localparam int SH_W    = LW + NORM_BIT;
    localparam int PAN0    = 8;
    localparam int TILT0   = PAN0 + N;
    localparam int SA_IDX  = TILT0 + N;
    localparam int DIV0    = SA_IDX + 1;
    localparam int OUT_IDX = DIV0 + NUM_W;
    localparam int DEPTH   = OUT_IDX + 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] orient_reg [3];
    logic [CFG_DATA_W-1:0] fixture_reg;
    logic [RANGE_W-1:0]    pan_range_reg, tilt_range_reg;
    logic [31:0]           center_reg;
    logic [1:0]            invert_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orient_reg[0]  <= ORIENT_ROW_0_RST;
            orient_reg[1]  <= ORIENT_ROW_1_RST;
            orient_reg[2]  <= ORIENT_ROW_2_RST;
            fixture_reg    <= '0;
            pan_range_reg  <= PAN_RANGE_RST;
            tilt_range_reg <= TILT_RANGE_RST;
            center_reg     <= CENTER_RST;
            invert_reg     <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_ORIENT_ROW_0:     orient_reg[0]  <= cfg.data;
                REG_ORIENT_ROW_1:     orient_reg[1]  <= cfg.data;
                REG_ORIENT_ROW_2:     orient_reg[2]  <= cfg.data;
                REG_FIXTURE_POSITION: fixture_reg    <= cfg.data;
                REG_PAN_RANGE_DEG:    pan_range_reg  <= cfg.data[RANGE_W-1:0];
                REG_TILT_RANGE_DEG:   tilt_range_reg <= cfg.data[RANGE_W-1:0];
                REG_CENTER_POSITIONS: center_reg     <= cfg.data[31:0];
                REG_INVERT_FLAGS:     invert_reg     <= cfg.data[1:0];
            endcase
        end
    end

    // zero range acts as one degree
    logic [RANGE_W-1:0] pan_div, tilt_div;
    assign pan_div  = (pan_range_reg == '0) ? RANGE_W'(1) : pan_range_reg;
    assign tilt_div = (tilt_range_reg == '0) ? RANGE_W'(1) : tilt_range_reg;

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    logic             adv;
    logic [DEPTH-1:0] valid_reg;

    assign adv          = !valid_reg[OUT_IDX] || result.ready;
    assign aim.ready    = adv;
    assign result.valid = valid_reg[OUT_IDX];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[DEPTH-2:0], aim.valid};
    end

    // ------------------------------------------------------------------
    // S1: world vector, fixture subtracted for target points
    // ------------------------------------------------------------------
    logic [64+CW-1:0]       fix_wide;
    logic signed [CW-1:0]   fix_sel [3];
    logic signed [CW-1:0]   vec_in  [3];
    logic signed [DW-1:0]   d_next  [3];
    logic signed [DW-1:0]   d_reg   [3];

    assign fix_wide  = (64 + CW)'(fixture_reg);
    assign vec_in[0] = aim.vec_x;
    assign vec_in[1] = aim.vec_y;
    assign vec_in[2] = aim.vec_z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (k * CW >= 64)
                fix_sel[k] = '0;
            else
                fix_sel[k] = signed'(fix_wide[k*CW +: CW]);
            d_next[k] = DW'(vec_in[k]);
            if (aim.opcode)
                d_next[k] = d_next[k] - DW'(fix_sel[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            d_reg <= d_next;
    end

    // ------------------------------------------------------------------
    // S2: matrix products, R^T d
    // ------------------------------------------------------------------
    logic signed [PW-1:0] prod_reg [3][3];
    logic                 s2_zero_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_zero_reg <= (d_reg[0] == '0) && (d_reg[1] == '0) && (d_reg[2] == '0);
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    prod_reg[r][c] <= PW'(signed'(orient_reg[r][c*ORIENT_W +: ORIENT_W]))
                                    * PW'(d_reg[r]);
        end
    end

    // ------------------------------------------------------------------
    // S3: column sums
    // ------------------------------------------------------------------
    logic signed [LW-1:0] l3_reg [3];
    logic                 s3_zero_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_zero_reg <= s2_zero_reg;
            for (int c = 0; c < 3; c++)
                l3_reg[c] <= LW'(prod_reg[0][c]) + LW'(prod_reg[1][c]) + LW'(prod_reg[2][c]);
        end
    end

    // ------------------------------------------------------------------
    // S4: magnitude mask (leading one of the OR equals that of the max)
    // ------------------------------------------------------------------
    logic [LW-1:0]        mag [3];
    logic [LW-1:0]        or_reg;
    logic signed [LW-1:0] l4_reg [3];
    logic                 s4_zero_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            mag[c] = (l3_reg[c] < 0) ? LW'(-l3_reg[c]) : LW'(l3_reg[c]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            or_reg      <= mag[0] | mag[1] | mag[2];
            l4_reg      <= l3_reg;
            s4_zero_reg <= s3_zero_reg;
        end
    end

    // ------------------------------------------------------------------
    // S5: leading-one position
    // ------------------------------------------------------------------
    logic [MSB_W-1:0]     msb_next, msb_reg;
    logic signed [LW-1:0] l5_reg [3];
    logic                 s5_zero_reg;

    always_comb
    begin
        msb_next = '0;
        for (int i = 0; i < LW; i++)
            if (or_reg[i])
                msb_next = MSB_W'(i);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            msb_reg     <= msb_next;
            l5_reg      <= l4_reg;
            s5_zero_reg <= s4_zero_reg;
        end
    end

    // ------------------------------------------------------------------
    // S6: normalize so the largest magnitude has its MSB at NORM_BIT
    // ------------------------------------------------------------------
    logic signed [SH_W-1:0] sh_src [3];
    logic signed [SH_W-1:0] sh_out [3];
    logic signed [NW-1:0]   n_reg  [3];
    logic                   s6_zero_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sh_src[c] = signed'({l5_reg[c], {NORM_BIT{1'b0}}});
            sh_out[c] = sh_src[c] >>> msb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
                n_reg[c] <= sh_out[c][NW-1:0];
            s6_zero_reg <= s5_zero_reg;
        end
    end

    // ------------------------------------------------------------------
    // S7: half-plane fold for pan, split gain products for tilt
    // ------------------------------------------------------------------
    logic signed [XW-1:0]        a_ext, b_ext, a_next, b_next;
    logic signed [ZW-1:0]        base_next;
    logic [SPLIT-1:0]            ly_lo;
    logic signed [NW-SPLIT-1:0]  ly_hi;
    logic [2*SPLIT-1:0]          plo_reg;
    logic signed [NW-SPLIT+GAIN_W-1:0] phi_reg;
    logic signed [XW-1:0]        a7_reg, b7_reg;
    logic signed [ZW-1:0]        base7_reg;
    logic                        s7_zero_reg;

    always_comb
    begin
        a_ext     = XW'(n_reg[0]);
        b_ext     = XW'(n_reg[2]);
        a_next    = a_ext;
        b_next    = b_ext;
        base_next = '0;
        if (b_ext < 0)
        begin
            base_next = (a_ext >= 0) ? ANG_180 : -ANG_180;
            a_next    = -a_ext;
            b_next    = -b_ext;
        end
        ly_lo = n_reg[1][SPLIT-1:0];
        ly_hi = n_reg[1][NW-1:SPLIT];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a7_reg      <= a_next;
            b7_reg      <= b_next;
            base7_reg   <= base_next;
            plo_reg     <= (2*SPLIT)'(ly_lo) * (2*SPLIT)'(GAIN_Q20[SPLIT-1:0]);
            phi_reg     <= (NW-SPLIT+GAIN_W)'(ly_hi) * (NW-SPLIT+GAIN_W)'(GAIN_Q20);
            s7_zero_reg <= s6_zero_reg;
        end
    end

    // ------------------------------------------------------------------
    // S8: gain-compensated y for the tilt CORDIC
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] ly_full;
    logic signed [XW-1:0]    ly8_reg, x8_reg, y8_reg;
    logic signed [ZW-1:0]    base8_reg;
    logic                    s8_zero_reg;

    assign ly_full = (SUM_W'(phi_reg) <<< SPLIT) + signed'(SUM_W'(plo_reg));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ly8_reg     <= XW'(ly_full >>> GAIN_FRAC);
            x8_reg      <= b7_reg;
            y8_reg      <= a7_reg;
            base8_reg   <= base7_reg;
            s8_zero_reg <= s7_zero_reg;
        end
    end

    // ------------------------------------------------------------------
    // pan CORDIC: atan2(x, z) and hypot
    // ------------------------------------------------------------------
    logic signed [XW-1:0] pan_x [N];
    logic signed [XW-1:0] pan_y [N];
    logic signed [ZW-1:0] pan_z [N];
    logic signed [ZW-1:0] pan_base_reg [N];
    logic signed [XW-1:0] pan_ly_reg   [N];
    logic                 pan_zero_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_pan
        logic signed [XW-1:0] xs, ys, lys;
        logic signed [ZW-1:0] zs, bs;
        logic                 zf;

        if (i == 0)
        begin : g_src
            assign xs  = x8_reg;
            assign ys  = y8_reg;
            assign zs  = '0;
            assign bs  = base8_reg;
            assign lys = ly8_reg;
            assign zf  = s8_zero_reg;
        end
        else
        begin : g_src
            assign xs  = pan_x[i-1];
            assign ys  = pan_y[i-1];
            assign zs  = pan_z[i-1];
            assign bs  = pan_base_reg[i-1];
            assign lys = pan_ly_reg[i-1];
            assign zf  = pan_zero_reg[i-1];
        end

        ptas_cordic_stage #(.STAGE(i)) u_stage (
            .clk   (clk),
            .en    (adv),
            .x_in  (xs),
            .y_in  (ys),
            .z_in  (zs),
            .x_out (pan_x[i]),
            .y_out (pan_y[i]),
            .z_out (pan_z[i])
        );

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pan_base_reg[i] <= bs;
                pan_ly_reg[i]   <= lys;
                pan_zero_reg[i] <= zf;
            end
        end
    end

    // ------------------------------------------------------------------
    // tilt CORDIC: atan2(y, hypot(x, z))
    // ------------------------------------------------------------------
    logic signed [XW-1:0] tilt_x [N];
    logic signed [XW-1:0] tilt_y [N];
    logic signed [ZW-1:0] tilt_z [N];
    logic signed [ZW-1:0] tilt_pan_reg  [N];
    logic                 tilt_zero_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_tilt
        logic signed [XW-1:0] xs, ys;
        logic signed [ZW-1:0] zs, ps;
        logic                 zf;

        if (i == 0)
        begin : g_src
            assign xs = pan_x[N-1];
            assign ys = pan_ly_reg[N-1];
            assign zs = '0;
            assign ps = pan_base_reg[N-1] + pan_z[N-1];
            assign zf = pan_zero_reg[N-1];
        end
        else
        begin : g_src
            assign xs = tilt_x[i-1];
            assign ys = tilt_y[i-1];
            assign zs = tilt_z[i-1];
            assign ps = tilt_pan_reg[i-1];
            assign zf = tilt_zero_reg[i-1];
        end

        ptas_cordic_stage #(.STAGE(i)) u_stage (
            .clk   (clk),
            .en    (adv),
            .x_in  (xs),
            .y_in  (ys),
            .z_in  (zs),
            .x_out (tilt_x[i]),
            .y_out (tilt_y[i]),
            .z_out (tilt_z[i])
        );

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                tilt_pan_reg[i]  <= ps;
                tilt_zero_reg[i] <= zf;
            end
        end
    end

    // ------------------------------------------------------------------
    // SA: inversion, sign/magnitude and rounding bias
    // ------------------------------------------------------------------
    logic signed [ZW-1:0] pan_ang, tilt_ang;
    logic [NUM_W-1:0]     pan_num_next, tilt_num_next;
    logic [NUM_W-1:0]     pan_num_reg, tilt_num_reg;
    logic                 pan_neg_reg, tilt_neg_reg, sa_zero_reg;

    always_comb
    begin
        pan_ang  = invert_reg[INV_PAN]  ? -tilt_pan_reg[N-1] : tilt_pan_reg[N-1];
        tilt_ang = invert_reg[INV_TILT] ? -tilt_z[N-1]       : tilt_z[N-1];
        pan_num_next  = ((pan_ang < 0) ? NUM_W'(-pan_ang) : NUM_W'(pan_ang))
                      + NUM_W'(pan_div >> 1);
        tilt_num_next = ((tilt_ang < 0) ? NUM_W'(-tilt_ang) : NUM_W'(tilt_ang))
                      + NUM_W'(tilt_div >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pan_num_reg  <= pan_num_next;
            tilt_num_reg <= tilt_num_next;
            pan_neg_reg  <= (pan_ang < 0);
            tilt_neg_reg <= (tilt_ang < 0);
            sa_zero_reg  <= tilt_zero_reg[N-1];
        end
    end

    // ------------------------------------------------------------------
    // dividers: angle / range, one quotient bit per stage, MSB first
    // ------------------------------------------------------------------
    logic [NUM_W-1:0]   pn [NUM_W];
    logic [RANGE_W-1:0] pr [NUM_W];
    logic [NUM_W-1:0]   pq [NUM_W];
    logic [NUM_W-1:0]   tn [NUM_W];
    logic [RANGE_W-1:0] tr [NUM_W];
    logic [NUM_W-1:0]   tq [NUM_W];
    logic               div_pneg_reg [NUM_W];
    logic               div_tneg_reg [NUM_W];
    logic               div_zero_reg [NUM_W];

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_div
        logic [NUM_W-1:0]   pn_s, tn_s, pq_s, tq_s;
        logic [RANGE_W-1:0] pr_s, tr_s;
        logic               pneg_s, tneg_s, zf;

        if (k == 0)
        begin : g_src
            assign pn_s   = pan_num_reg;
            assign tn_s   = tilt_num_reg;
            assign pr_s   = '0;
            assign tr_s   = '0;
            assign pq_s   = '0;
            assign tq_s   = '0;
            assign pneg_s = pan_neg_reg;
            assign tneg_s = tilt_neg_reg;
            assign zf     = sa_zero_reg;
        end
        else
        begin : g_src
            assign pn_s   = pn[k-1];
            assign tn_s   = tn[k-1];
            assign pr_s   = pr[k-1];
            assign tr_s   = tr[k-1];
            assign pq_s   = pq[k-1];
            assign tq_s   = tq[k-1];
            assign pneg_s = div_pneg_reg[k-1];
            assign tneg_s = div_tneg_reg[k-1];
            assign zf     = div_zero_reg[k-1];
        end

        ptas_div_stage #(.BIT(NUM_W - 1 - k)) u_pan_div (
            .clk     (clk),
            .en      (adv),
            .divisor (pan_div),
            .num_in  (pn_s),
            .rem_in  (pr_s),
            .quo_in  (pq_s),
            .num_out (pn[k]),
            .rem_out (pr[k]),
            .quo_out (pq[k])
        );

        ptas_div_stage #(.BIT(NUM_W - 1 - k)) u_tilt_div (
            .clk     (clk),
            .en      (adv),
            .divisor (tilt_div),
            .num_in  (tn_s),
            .rem_in  (tr_s),
            .quo_in  (tq_s),
            .num_out (tn[k]),
            .rem_out (tr[k]),
            .quo_out (tq[k])
        );

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_pneg_reg[k] <= pneg_s;
                div_tneg_reg[k] <= tneg_s;
                div_zero_reg[k] <= zf;
            end
        end
    end

    // ------------------------------------------------------------------
    // output register: center offset, clamp, reachability
    // ------------------------------------------------------------------
    logic signed [V_W-1:0] pan_q, tilt_q, pan_v, tilt_v;
    logic [POS_W-1:0]      pan_pos_next, tilt_pos_next;
    logic                  reach_next;
    logic [POS_W-1:0]      pan_pos_reg, tilt_pos_reg;
    logic                  reach_reg;

    always_comb
    begin
        pan_q  = signed'(V_W'(pq[NUM_W-1]));
        tilt_q = signed'(V_W'(tq[NUM_W-1]));
        if (div_pneg_reg[NUM_W-1])
            pan_q = -pan_q;
        if (div_tneg_reg[NUM_W-1])
            tilt_q = -tilt_q;
        pan_v  = signed'(V_W'(center_reg[POS_W-1:0])) + pan_q;
        tilt_v = signed'(V_W'(center_reg[2*POS_W-1:POS_W])) + tilt_q;

        reach_next = !(pan_v < 0 || pan_v > POS_ONE || tilt_v < 0 || tilt_v > POS_ONE);

        priority if (pan_v < 0)
            pan_pos_next = '0;
        else if (pan_v >= POS_ONE)
            pan_pos_next = POS_MAX;
        else
            pan_pos_next = pan_v[POS_W-1:0];

        priority if (tilt_v < 0)
            tilt_pos_next = '0;
        else if (tilt_v >= POS_ONE)
            tilt_pos_next = POS_MAX;
        else
            tilt_pos_next = tilt_v[POS_W-1:0];

        // zero world vector: centers, not reachable
        if (div_zero_reg[NUM_W-1])
        begin
            pan_pos_next  = center_reg[POS_W-1:0];
            tilt_pos_next = center_reg[2*POS_W-1:POS_W];
            reach_next    = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pan_pos_reg  <= pan_pos_next;
            tilt_pos_reg <= tilt_pos_next;
            reach_reg    <= reach_next;
        end
    end

    assign result.pan_position  = pan_pos_reg;
    assign result.tilt_position = tilt_pos_reg;
    assign result.reachable     = reach_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `PTAS_ASSERT_IMPLIES(a_pan_hyp_nonneg, clk, rst_n, valid_reg[TILT0-1],
        !pan_x[N-1][XW-1], "pan CORDIC x went negative")
    `PTAS_ASSERT_IMPLIES(a_rem_below_div, clk, rst_n, valid_reg[OUT_IDX-1],
        (pr[NUM_W-1] < pan_div) && (tr[NUM_W-1] < tilt_div),
        "divider remainder not below divisor")
    `PTAS_ASSERT_NEXT(a_stall_holds, clk, rst_n, !adv, $stable(valid_reg),
        "pipeline moved during stall")
    `PTAS_ASSERT_NEXT(a_zero_unreachable, clk, rst_n,
        adv && valid_reg[OUT_IDX-1] && div_zero_reg[NUM_W-1],
        !result.reachable, "zero vector reported reachable")

endmodule
